@@ hdl/escape_time_fractal_pixel_defines.svh @@
// assertion helpers for the escape time fractal pixel block
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_DEFINES_SVH

// same cycle implication, clocked on clk_i, off while rst_ni is low
`define EFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next cycle implication, clocked on clk_i, off while rst_ni is low
`define EFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/efp_pkg.sv @@
`timescale 1ns / 1ps
package efp_pkg;

  localparam int unsigned COORD_BITS    = 12;
  localparam int unsigned FRAC_BITS     = 26;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned CNT_W         = 16;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned PROD_W        = 2 * VAL_W;
  localparam int unsigned MAP_W         = COORD_BITS + 1 + VAL_W;
  localparam int unsigned ESC_RADIUS_SQ = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // escape test only makes sense while the limit still fits the square sum
  localparam bit ESC_ON = (2 * FRAC_BITS + 4) < PROD_W;
  localparam logic [PROD_W-1:0] ESC_LIMIT =
    ESC_ON ? (PROD_W'(ESC_RADIUS_SQ) << (2 * FRAC_BITS)) : '1;

  typedef logic signed [VAL_W-1:0] fix_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [CNT_W-1:0]      iteration_count;
  } result_t;

  typedef struct packed {
    fix_t             x_step;
    fix_t             y_step;
    fix_t             x_origin;
    fix_t             y_origin;
    logic [CNT_W-1:0] max_iterations;
    logic             set_mode;
    fix_t             julia_real;
    fix_t             julia_imag;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    x_step:         32'sd262144,
    y_step:         32'sd262144,
    x_origin:       -32'sd134217728,
    y_origin:       -32'sd134217728,
    max_iterations: 16'd256,
    set_mode:       1'b1,
    julia_real:     '0,
    julia_imag:     '0
  };

  typedef struct packed {
    pixel_t pixel;
    logic   out_of_range;
    fix_t   re;
    fix_t   im;
    fix_t   cr;
    fix_t   ci;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_STEP,
    REG_Y_STEP,
    REG_X_ORIGIN,
    REG_Y_ORIGIN,
    REG_MAX_ITER,
    REG_SET_MODE,
    REG_JULIA_RE,
    REG_JULIA_IM
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_UPD,
    ST_FIN
  } back_state_e;

  // true when a wide signed value still fits the fixed point word
  function automatic logic fits_val(input logic [PROD_W-1:0] v);
    return (v[PROD_W-1:VAL_W-1] == '0) || (v[PROD_W-1:VAL_W-1] == '1);
  endfunction

endpackage

@@ hdl/efp_cfg.sv @@
`timescale 1ns / 1ps
module efp_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [efp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [efp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output efp_pkg::cfg_t                    cfg_o
);

  efp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (efp_pkg::cfg_reg_e'(cfg_idx_i))
        efp_pkg::REG_X_STEP:   cfg_d.x_step = cfg_data_i[efp_pkg::VAL_W-1:0];
        efp_pkg::REG_Y_STEP:   cfg_d.y_step = cfg_data_i[efp_pkg::VAL_W-1:0];
        efp_pkg::REG_X_ORIGIN: cfg_d.x_origin = cfg_data_i[efp_pkg::VAL_W-1:0];
        efp_pkg::REG_Y_ORIGIN: cfg_d.y_origin = cfg_data_i[efp_pkg::VAL_W-1:0];
        efp_pkg::REG_MAX_ITER: cfg_d.max_iterations = cfg_data_i[efp_pkg::CNT_W-1:0];
        efp_pkg::REG_SET_MODE: cfg_d.set_mode = cfg_data_i[0];
        efp_pkg::REG_JULIA_RE: cfg_d.julia_real = cfg_data_i[efp_pkg::VAL_W-1:0];
        efp_pkg::REG_JULIA_IM: cfg_d.julia_imag = cfg_data_i[efp_pkg::VAL_W-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= efp_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/efp_front.sv @@
`timescale 1ns / 1ps
module efp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  efp_pkg::pixel_t    pixel_i,
  input  efp_pkg::cfg_t      cfg_i,
  input  efp_pkg::q_status_t q_status_i,
  output logic               job_push_o,
  output efp_pkg::job_t      job_o
);

  logic m_v_q, m_v_d;
  logic take, leave;

  efp_pkg::pixel_t                    pix_q;
  logic signed [efp_pkg::MAP_W-1:0]   px_prod_q, py_prod_q;
  logic signed [efp_pkg::MAP_W:0]     re_sum, im_sum;
  logic                               re_fits, im_fits;

  assign leave      = m_v_q && !q_status_i.full;
  assign full       = m_v_q && q_status_i.full;
  assign take       = push && !full;
  assign job_push_o = leave;

  always_comb begin
    m_v_d = m_v_q;
    if (take) begin
      m_v_d = 1'b1;
    end else if (leave) begin
      m_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else begin
      m_v_q <= m_v_d;
    end
  end

  // pixel to plane: column and row times step
  always_ff @(posedge clk_i) begin
    if (take) begin
      pix_q     <= pixel_i;
      px_prod_q <= $signed({1'b0, pixel_i.pixel_x}) * $signed(cfg_i.x_step);
      py_prod_q <= $signed({1'b0, pixel_i.pixel_y}) * $signed(cfg_i.y_step);
    end
  end

  // add origin, classify out of range points, pick the constant
  always_comb begin
    re_sum  = (efp_pkg::MAP_W + 1)'(px_prod_q) +
              (efp_pkg::MAP_W + 1)'($signed(cfg_i.x_origin));
    im_sum  = (efp_pkg::MAP_W + 1)'(py_prod_q) +
              (efp_pkg::MAP_W + 1)'($signed(cfg_i.y_origin));
    re_fits = efp_pkg::fits_val(efp_pkg::PROD_W'(re_sum));
    im_fits = efp_pkg::fits_val(efp_pkg::PROD_W'(im_sum));

    job_o.pixel        = pix_q;
    job_o.out_of_range = !(re_fits && im_fits);
    job_o.re           = re_sum[efp_pkg::VAL_W-1:0];
    job_o.im           = im_sum[efp_pkg::VAL_W-1:0];
    job_o.cr           = cfg_i.set_mode ? re_sum[efp_pkg::VAL_W-1:0] : cfg_i.julia_real;
    job_o.ci           = cfg_i.set_mode ? im_sum[efp_pkg::VAL_W-1:0] : cfg_i.julia_imag;
  end

endmodule

@@ hdl/efp_queue.sv @@
`timescale 1ns / 1ps
`include "escape_time_fractal_pixel_defines.svh"
module efp_queue #(
  parameter int unsigned DEPTH = efp_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  efp_pkg::job_t      job_i,
  input  logic               pop_i,
  output efp_pkg::job_t      job_o,
  output efp_pkg::q_status_t status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  efp_pkg::job_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign job_o          = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `EFP_ASSERT_NEXT(a_q_push_grows, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow on push")
  `EFP_ASSERT_NOW(a_q_empty_ptrs, cnt_q == '0, rd_ptr_q == wr_ptr_q, "empty queue with pointers apart")

endmodule

@@ hdl/efp_back.sv @@
`timescale 1ns / 1ps
`include "escape_time_fractal_pixel_defines.svh"
module efp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  efp_pkg::cfg_t      cfg_i,
  input  efp_pkg::job_t      job_i,
  input  efp_pkg::q_status_t q_status_i,
  output logic               job_pop_o,
  output logic               empty,
  input  logic               pop,
  output efp_pkg::result_t   result_o
);

  localparam int unsigned PW = efp_pkg::PROD_W;
  localparam int unsigned VW = efp_pkg::VAL_W;

  efp_pkg::back_state_e state_q, state_d;

  efp_pkg::pixel_t          pix_q, pix_d;
  efp_pkg::fix_t            re_q, re_d, im_q, im_d, cr_q, cr_d, ci_q, ci_d;
  logic [efp_pkg::CNT_W-1:0] n_q, n_d, n_inc;
  logic                     chk_q, chk_d;
  logic signed [PW-1:0]     rr_q, rr_d, ii_q, ii_d, ri_q, ri_d, diff_q, diff_d;
  logic [PW-1:0]            sq_q, sq_d;
  logic signed [PW-1:0]     nr, ni;
  logic                     escaped, ovf;
  efp_pkg::result_t         res_q, res_d;
  logic                     res_v_q, res_v_d;

  always_comb begin
    n_inc   = chk_q ? n_q + 1'b1 : n_q;
    escaped = chk_q && efp_pkg::ESC_ON && (sq_q > efp_pkg::ESC_LIMIT);
    nr      = (diff_q >>> efp_pkg::FRAC_BITS) + PW'(cr_q);
    ni      = (ri_q >>> (efp_pkg::FRAC_BITS - 1)) + PW'(ci_q);
    ovf     = !efp_pkg::fits_val(nr) || !efp_pkg::fits_val(ni);
  end

  always_comb begin
    state_d   = state_q;
    pix_d     = pix_q;
    re_d      = re_q;
    im_d      = im_q;
    cr_d      = cr_q;
    ci_d      = ci_q;
    n_d       = n_q;
    chk_d     = chk_q;
    rr_d      = rr_q;
    ii_d      = ii_q;
    ri_d      = ri_q;
    sq_d      = sq_q;
    diff_d    = diff_q;
    res_d     = res_q;
    res_v_d   = res_v_q;
    job_pop_o = 1'b0;

    if (pop && res_v_q) begin
      res_v_d = 1'b0;
    end

    unique case (state_q)
      efp_pkg::ST_IDLE: begin
        if (!q_status_i.empty) begin
          job_pop_o = 1'b1;
          pix_d     = job_i.pixel;
          re_d      = job_i.re;
          im_d      = job_i.im;
          cr_d      = job_i.cr;
          ci_d      = job_i.ci;
          n_d       = '0;
          chk_d     = 1'b0;
          state_d   = job_i.out_of_range ? efp_pkg::ST_FIN : efp_pkg::ST_MUL;
        end
      end
      efp_pkg::ST_MUL: begin
        rr_d    = re_q * re_q;
        ii_d    = im_q * im_q;
        ri_d    = re_q * im_q;
        state_d = efp_pkg::ST_SUM;
      end
      efp_pkg::ST_SUM: begin
        sq_d    = $unsigned(rr_q) + $unsigned(ii_q);
        diff_d  = rr_q - ii_q;
        state_d = efp_pkg::ST_UPD;
      end
      efp_pkg::ST_UPD: begin
        // escape of the last update is checked before counting it
        if (escaped) begin
          state_d = efp_pkg::ST_FIN;
        end else begin
          n_d   = n_inc;
          chk_d = 1'b1;
          if ((n_inc >= cfg_i.max_iterations) || ovf) begin
            state_d = efp_pkg::ST_FIN;
          end else begin
            re_d    = nr[VW-1:0];
            im_d    = ni[VW-1:0];
            state_d = efp_pkg::ST_MUL;
          end
        end
      end
      efp_pkg::ST_FIN: begin
        if (!res_v_d) begin
          res_d.out_x           = pix_q.pixel_x;
          res_d.out_y           = pix_q.pixel_y;
          res_d.iteration_count = n_q;
          res_v_d               = 1'b1;
          state_d               = efp_pkg::ST_IDLE;
        end
      end
      default: state_d = efp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= efp_pkg::ST_IDLE;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= pix_d;
    re_q   <= re_d;
    im_q   <= im_d;
    cr_q   <= cr_d;
    ci_q   <= ci_d;
    n_q    <= n_d;
    chk_q  <= chk_d;
    rr_q   <= rr_d;
    ii_q   <= ii_d;
    ri_q   <= ri_d;
    sq_q   <= sq_d;
    diff_q <= diff_d;
    res_q  <= res_d;
  end

  assign empty    = !res_v_q;
  assign result_o = res_q;

  `EFP_ASSERT_NEXT(a_upd_exit, state_q == efp_pkg::ST_UPD, state_q == efp_pkg::ST_MUL || state_q == efp_pkg::ST_FIN, "update step went to an unexpected state")
  `EFP_ASSERT_NEXT(a_fin_fill, state_q == efp_pkg::ST_FIN && !res_v_q, res_v_q && state_q == efp_pkg::ST_IDLE, "finished pixel not moved to the result register")

endmodule

@@ hdl/escape_time_fractal_pixel.sv @@
`timescale 1ns / 1ps
// front end multiplies pixel by step on the accept edge, adds origin and queues it once the queue has room
// back end pass runs multiply, sum and update states, one pass per counted iteration plus a last check on escape
// out of range pixels skip the passes; the back end takes the next pixel from the queue only when idle
// new pixels accepted while results wait until front register and 2 entry queue are full
// rst_ni is asynchronous, active low: clears queue and control, loads register defaults
module escape_time_fractal_pixel #(
  parameter int unsigned QUEUE_DEPTH = efp_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  efp_pkg::pixel_t                pixel_i,
  output logic                           empty,
  input  logic                           pop,
  output efp_pkg::result_t               result_o,
  input  logic                           cfg_we_i,
  input  logic [efp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [efp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  efp_pkg::cfg_t      cfg;
  efp_pkg::job_t      front_job, queue_job;
  efp_pkg::q_status_t q_status;
  logic               job_push, job_pop;

  efp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  efp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .pixel_i    (pixel_i),
    .cfg_i      (cfg),
    .q_status_i (q_status),
    .job_push_o (job_push),
    .job_o      (front_job)
  );

  efp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (job_push),
    .job_i    (front_job),
    .pop_i    (job_pop),
    .job_o    (queue_job),
    .status_o (q_status)
  );

  efp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .job_i      (queue_job),
    .q_status_i (q_status),
    .job_pop_o  (job_pop),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

endmodule
